FILE: hdl/emt_pkg.sv
// Shared types and constants for the empty-marker table.
`timescale 1ns / 1ps
`default_nettype none

package emt_pkg;

  localparam int unsigned ENTRIES_DEFAULT = 8;

  localparam int unsigned SRC_W   = 8;
  localparam int unsigned NIGHT_W = 64;
  localparam int unsigned DUR_W   = 32;
  localparam int unsigned CNT_W   = 32;

  // Input request packing, lowest bit first.
  localparam int unsigned CMD_LSB   = 0;
  localparam int unsigned SRC_LSB   = 2;
  localparam int unsigned NIGHT_LSB = SRC_LSB + SRC_W;
  localparam int unsigned DUR_LSB   = NIGHT_LSB + NIGHT_W;
  localparam int unsigned CNT_LSB   = DUR_LSB + DUR_W;
  localparam int unsigned IN_BITS   = CNT_LSB + CNT_W;
  localparam int unsigned IN_DATA_W = ((IN_BITS + 7) / 8) * 8;
  localparam int unsigned OUT_DATA_W = 8;

  typedef enum logic [1:0] {
    CMD_CLEAR  = 2'd0,
    CMD_NOTE   = 2'd1,
    CMD_QUERY  = 2'd2,
    CMD_UNUSED = 2'd3
  } cmd_t;

  // A request as it walks down the row of cells. The hit flag means "written"
  // for a note and "full match found" for a query.
  typedef struct packed {
    logic               valid;
    cmd_t               cmd;
    logic [SRC_W-1:0]   src;
    logic [NIGHT_W-1:0] night;
    logic [DUR_W-1:0]   dur;
    logic [CNT_W-1:0]   cnt;
    logic               hit;
  } token_t;

endpackage

`default_nettype wire

FILE: hdl/emt_cell.sv
// One marker cell: holds one entry and processes the request passing through.
`timescale 1ns / 1ps
`default_nettype none

module emt_cell (
  input  wire logic          clk,
  input  wire logic          rst,
  input  emt_pkg::token_t    tok_in,
  input  emt_pkg::token_t    fill,
  output emt_pkg::token_t    tok_out
);

  logic [emt_pkg::SRC_W-1:0]   e_src;
  logic [emt_pkg::NIGHT_W-1:0] e_night;
  logic [emt_pkg::DUR_W-1:0]   e_dur;
  logic [emt_pkg::CNT_W-1:0]   e_cnt;
  logic                        e_keyed;

  emt_pkg::token_t tok_next;
  logic            clr;
  logic            wr;
  logic            same_slot;

  assign same_slot = (e_src == tok_in.src) && (e_night == tok_in.night);

  always_comb begin
    tok_next = tok_in;
    clr      = 1'b0;
    wr       = 1'b0;
    if (tok_in.valid) begin
      case (tok_in.cmd)
        emt_pkg::CMD_CLEAR: begin
          clr = (tok_in.night == '0) || (e_night == tok_in.night);
        end
        emt_pkg::CMD_NOTE: begin
          if (!tok_in.hit && (same_slot || (e_night == '0))) begin
            wr           = 1'b1;
            tok_next.hit = 1'b1;
          end
        end
        emt_pkg::CMD_QUERY: begin
          if (same_slot && e_keyed && (e_dur == tok_in.dur) && (e_cnt == tok_in.cnt)) begin
            tok_next.hit = 1'b1;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // The fill port is the table-full fallback write; it never coincides with
  // a request in this cell.
  always_ff @(posedge clk) begin
    if (rst) begin
      e_src   <= '0;
      e_night <= '0;
      e_dur   <= '0;
      e_cnt   <= '0;
      e_keyed <= 1'b0;
    end else if (fill.valid) begin
      e_src   <= fill.src;
      e_night <= fill.night;
      e_dur   <= fill.dur;
      e_cnt   <= fill.cnt;
      e_keyed <= 1'b1;
    end else if (wr) begin
      e_src   <= tok_in.src;
      e_night <= tok_in.night;
      e_dur   <= tok_in.dur;
      e_cnt   <= tok_in.cnt;
      e_keyed <= 1'b1;
    end else if (clr) begin
      e_src   <= '0;
      e_night <= '0;
      e_dur   <= '0;
      e_cnt   <= '0;
      e_keyed <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tok_out.valid <= 1'b0;
    end else begin
      tok_out.valid <= tok_next.valid;
    end
    tok_out.cmd   <= tok_next.cmd;
    tok_out.src   <= tok_next.src;
    tok_out.night <= tok_next.night;
    tok_out.dur   <= tok_next.dur;
    tok_out.cnt   <= tok_next.cnt;
    tok_out.hit   <= tok_next.hit;
  end

endmodule

`default_nettype wire

FILE: hdl/empty_marker_table_top.sv
// Top level of the empty-marker table: input stage, row of cells, result stage.
// Path: an accepted request walks the row one cell per cycle, then passes the
// pending stage and the output register before its result is offered.
// Occupancy: one request in the row at a time; a new request is taken only
// once the last result has moved into the output register.
// Reset: synchronous, active high; every marker is emptied at once and no
// clearing pass is needed.
`timescale 1ns / 1ps
`default_nettype none

module empty_marker_table_top #(
  parameter int unsigned ENTRIES = emt_pkg::ENTRIES_DEFAULT
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  // Request side.
  input  wire logic                            s_tvalid,
  output logic                                 s_tready,
  // s_tdata, lowest bit up: command[1:0], source_id[9:2], night_start[73:10],
  // duration_minutes[105:74], interval_count[137:106], zero fill[143:138].
  input  wire logic [emt_pkg::IN_DATA_W-1:0]   s_tdata,
  // Result side.
  output logic                                 m_tvalid,
  input  wire logic                            m_tready,
  // m_tdata, lowest bit up: confirmed[0], zero fill[7:1].
  output logic [emt_pkg::OUT_DATA_W-1:0]       m_tdata
);

  // tok[i] feeds cell i; tok[ENTRIES] is the registered output of the last
  // cell, where the request leaves the row.
  emt_pkg::token_t tok [0:ENTRIES];
  emt_pkg::token_t fill0;
  emt_pkg::token_t no_fill;
  emt_pkg::token_t tail;

  logic             busy;
  logic             accept;
  logic             pend_valid;
  logic             pend_confirmed;
  logic             out_confirmed;
  logic             pend_move;
  logic [ENTRIES:0] tok_valid;

  assign accept   = s_tvalid && s_tready;
  // A request is taken only when the row and the pending stage are empty; a
  // result still waiting on the master side does not hold up the next one.
  assign s_tready = !busy;

  always_comb begin
    tok[0].valid = accept;
    tok[0].cmd   = emt_pkg::cmd_t'(s_tdata[emt_pkg::CMD_LSB +: 2]);
    tok[0].src   = s_tdata[emt_pkg::SRC_LSB +: emt_pkg::SRC_W];
    tok[0].night = s_tdata[emt_pkg::NIGHT_LSB +: emt_pkg::NIGHT_W];
    tok[0].dur   = s_tdata[emt_pkg::DUR_LSB +: emt_pkg::DUR_W];
    tok[0].cnt   = s_tdata[emt_pkg::CNT_LSB +: emt_pkg::CNT_W];
    tok[0].hit   = 1'b0;
  end

  assign tail = tok[ENTRIES];

  // When a note leaves the row without finding a matching or free marker,
  // marker 0 is overwritten in that same cycle. Cell 0 is idle then, since
  // only one request is in the row.
  always_comb begin
    fill0       = tail;
    fill0.valid = tail.valid && (tail.cmd == emt_pkg::CMD_NOTE) && !tail.hit;
  end

  assign no_fill = '0;

  for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
    emt_cell u_cell (
      .clk     (clk),
      .rst     (rst),
      .tok_in  (tok[i]),
      .fill    ((i == 0) ? fill0 : no_fill),
      .tok_out (tok[i+1])
    );
  end

  for (genvar i = 0; i <= ENTRIES; i++) begin : g_vld
    assign tok_valid[i] = tok[i].valid;
  end

  // The pending stage holds the finished result until the output register is
  // free, so the row never has to stall.
  assign pend_move = pend_valid && (!m_tvalid || m_tready);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy       <= 1'b0;
      pend_valid <= 1'b0;
      m_tvalid   <= 1'b0;
    end else begin
      if (accept) begin
        busy <= 1'b1;
      end else if (pend_move) begin
        busy <= 1'b0;
      end
      if (tail.valid) begin
        pend_valid <= 1'b1;
      end else if (pend_move) begin
        pend_valid <= 1'b0;
      end
      if (pend_move) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (tail.valid) begin
      pend_confirmed <= (tail.cmd == emt_pkg::CMD_QUERY) && tail.hit;
    end
    if (pend_move) begin
      out_confirmed <= pend_confirmed;
    end
  end

  assign m_tdata = {{(emt_pkg::OUT_DATA_W-1){1'b0}}, out_confirmed};

`ifndef SYNTHESIS
  // Only one request may ever be inside the row.
  a_one_token: assert property (@(posedge clk) disable iff (rst) $onehot0(tok_valid))
    else $error("more than one request in the cell row");

  // The pending stage must be empty when a request leaves the row.
  a_pend_free: assert property (@(posedge clk) disable iff (rst)
    tail.valid |-> !pend_valid)
    else $error("result arrived while pending stage full");

  // A waiting result keeps the block busy so no new request overtakes it.
  a_pend_busy: assert property (@(posedge clk) disable iff (rst)
    pend_valid |-> busy)
    else $error("pending result without busy");

  // An accepted request is tracked as busy from the next cycle on.
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    accept |=> busy && !s_tready)
    else $error("request accepted but block not busy");
`endif

endmodule

`default_nettype wire
